@@ rtl/rst_pkg.sv @@
// ----------------------------------------------------------------------------
// rst_pkg: shared constants for the record slot table
// Operation and status codes, default sizes, ID counter reset value and top ID.
// ----------------------------------------------------------------------------
package rst_pkg;
    localparam int DEPTH_DEF      = 16;
    localparam int NAME_BYTES_DEF = 8;
    localparam logic [15:0] LAST_ID_RST = 16'd1999;
    localparam logic [15:0] TOP_ID      = 16'hFFFF;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_RENAME = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_LOOKUP = 3'd3;
    localparam logic [2:0] OP_SORT   = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_EXH  = 2'd2;
endpackage

@@ rtl/record_slot_table_core.sv @@
// ----------------------------------------------------------------------------
// record_slot_table_core: slot table with ID lookup
// Insert, rename, remove, lookup, read and bubble sort on a slot memory.
// ----------------------------------------------------------------------------
// Insert scans the valid flops for the first free slot; rename, remove and lookup
// read and compare each slot in turn until the key is found or the table ends;
// sort runs compare passes over adjacent slots, writing both slots on a swap.
// One command at a time; busy is high from accept until the o_strobe cycle,
// in which the next start is taken. The strobe lasts one cycle, no stall.
// Reset (sync, active low) clears valid flops, then a zeroing pass over the memory.
module record_slot_table_core #(
    parameter int DEPTH      = rst_pkg::DEPTH_DEF,
    parameter int NAME_BYTES = rst_pkg::NAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_entry_name,
    input  logic [15:0] i_key_id,
    input  logic [3:0]  i_slot_index,
    input  logic        i_descending,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [3:0]  o_found_slot,
    output logic [15:0] o_entry_id,
    output logic        o_entry_valid,
    output logic [63:0] o_stored_name
);
    import rst_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = AW + 1;
    localparam logic [63:0] NAME_MASK = ~64'd0 << (8 * (8 - NAME_BYTES));
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [8:0]    DEPTH_W = 9'(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;  // issue read of r_idx
    localparam logic [3:0] S_CHK   = 4'd2;  // data back, compare
    localparam logic [3:0] S_DONE  = 4'd3;  // apply found slot
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_RDW   = 4'd5;
    localparam logic [3:0] S_SA    = 4'd6;  // read slot i
    localparam logic [3:0] S_SB    = 4'd7;  // read slot i+1, latch i
    localparam logic [3:0] S_SC    = 4'd8;  // compare, write i
    localparam logic [3:0] S_SD    = 4'd9;  // write i+1
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_CLR   = 4'd11; // zero one entry per cycle

    // memory: {id, name}; valid bits in flops
    logic [79:0]      mem [DEPTH];
    logic [79:0]      r_rdata;
    logic             r_we;
    logic             n_we;
    logic [AW-1:0]    r_waddr;
    logic [79:0]      r_wdata;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic [DEPTH-1:0] r_valid;

    logic [3:0]    r_state;
    logic [2:0]    r_op;
    logic [63:0]   r_name;
    logic [15:0]   r_key;
    logic          r_desc;
    logic [15:0]   r_last_id;
    logic [CW-1:0] r_idx;
    logic          r_swapped;
    logic [79:0]   r_a;
    logic          r_va;
    logic          r_vb;

    logic [1:0]  r_status;
    logic [3:0]  r_fslot;
    logic [15:0] r_eid;
    logic        r_ev;
    logic [63:0] r_sname;

    logic [AW-1:0] idx_a;
    assign idx_a = r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_waddr] <= r_wdata;
        // a write landing on the entry being read is forwarded
        if (rd_en) r_rdata <= (r_we && r_waddr == rd_addr) ? r_wdata : mem[rd_addr];
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_a;
        unique case (r_state)
            S_SCAN, S_RD, S_SA: rd_en = 1'b1;
            S_SB: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_idx + 1'b1);
            end
            default: rd_en = 1'b0;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    logic out_of_order;
    assign out_of_order = r_desc ? (r_a[63:0] < r_rdata[63:0])
                                 : (r_a[63:0] > r_rdata[63:0]);

    always_comb begin
        unique case (r_state)
            S_CLR, S_SD: n_we = 1'b1;
            S_SC:        n_we = out_of_order;
            S_DONE:      n_we = (r_op == OP_RENAME) ||
                                (r_op == OP_INSERT && r_last_id != TOP_ID);
            default:     n_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we      <= 1'b0;
            o_strobe  <= 1'b0;
            r_state   <= S_CLR;
            r_idx     <= '0;
            r_valid   <= '0;
            r_last_id <= LAST_ID_RST;
        end else begin
            r_we     <= n_we;
            o_strobe <= (r_state == S_OUT);
            unique case (r_state)
                S_CLR: begin
                    r_waddr <= idx_a;
                    r_wdata <= '0;
                    if (r_idx == DEPTH_C - 1'b1) r_state <= S_IDLE;
                    else r_idx <= r_idx + 1'b1;
                end
                S_IDLE: if (start) begin
                    r_op      <= i_operation;
                    r_name    <= i_entry_name & NAME_MASK;
                    r_key     <= i_key_id;
                    r_desc    <= i_descending;
                    r_idx     <= (i_operation == OP_READ) ? CW'(i_slot_index) : '0;
                    r_swapped <= 1'b0;
                    r_status  <= ST_FAIL;
                    r_fslot   <= '0;
                    r_eid     <= '0;
                    r_ev      <= 1'b0;
                    r_sname   <= '0;
                    unique case (i_operation)
                        OP_INSERT, OP_RENAME, OP_REMOVE, OP_LOOKUP: r_state <= S_SCAN;
                        OP_SORT:  r_state <= (DEPTH > 1) ? S_SA : S_OUT;
                        OP_READ:
                            r_state <= ({5'd0, i_slot_index} < DEPTH_W) ? S_RD : S_OUT;
                        default: r_state <= S_OUT;
                    endcase
                end
                S_SCAN: begin
                    if (r_op == OP_INSERT) begin
                        // no memory data needed: free slot search on valid flops
                        if (!r_valid[idx_a]) r_state <= S_DONE;
                        else if (r_idx == DEPTH_C - 1'b1) r_state <= S_OUT;
                        else r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_valid[idx_a] && r_rdata[79:64] == r_key) r_state <= S_DONE;
                    else if (r_idx == DEPTH_C - 1'b1) r_state <= S_OUT;
                    else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_DONE: begin
                    r_state <= S_OUT;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (r_last_id == TOP_ID) begin
                                r_status <= ST_EXH;
                            end else begin
                                r_status       <= ST_OK;
                                r_fslot        <= 4'(r_idx);
                                r_last_id      <= r_last_id + 16'd1;
                                r_valid[idx_a] <= 1'b1;
                                r_waddr        <= idx_a;
                                r_wdata        <= {r_last_id + 16'd1, r_name};
                                r_eid          <= r_last_id + 16'd1;
                                r_ev           <= 1'b1;
                                r_sname        <= r_name;
                            end
                        end
                        OP_RENAME: begin
                            r_status <= ST_OK;
                            r_fslot  <= 4'(r_idx);
                            r_waddr  <= idx_a;
                            r_wdata  <= {r_rdata[79:64], r_name};
                            r_eid    <= r_rdata[79:64];
                            r_ev     <= 1'b1;
                            r_sname  <= r_name;
                        end
                        OP_REMOVE: begin
                            r_status       <= ST_OK;
                            r_fslot        <= 4'(r_idx);
                            r_valid[idx_a] <= 1'b0;
                            r_eid          <= r_rdata[79:64];
                            r_sname        <= r_rdata[63:0];
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_fslot  <= 4'(r_idx);
                            r_eid    <= r_rdata[79:64];
                            r_ev     <= 1'b1;
                            r_sname  <= r_rdata[63:0];
                        end
                    endcase
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    r_status <= ST_OK;
                    r_fslot  <= 4'(r_idx);
                    r_ev     <= r_valid[idx_a];
                    r_eid    <= r_valid[idx_a] ? r_rdata[79:64] : 16'd0;
                    r_sname  <= r_rdata[63:0];
                    r_state  <= S_OUT;
                end
                S_SA: r_state <= S_SB;
                S_SB: begin
                    r_a     <= r_rdata;
                    r_state <= S_SC;
                end
                S_SC: begin
                    if (out_of_order) begin
                        r_waddr    <= idx_a;
                        r_wdata    <= r_rdata;
                        r_va       <= r_valid[idx_a];
                        r_vb       <= r_valid[AW'(r_idx + 1'b1)];
                        r_swapped  <= 1'b1;
                        r_state    <= S_SD;
                    end else if (r_idx == DEPTH_C - 2'd2) begin
                        r_idx     <= '0;
                        r_swapped <= 1'b0;
                        r_state   <= r_swapped ? S_SA : S_OUT;
                        if (!r_swapped) r_status <= ST_OK;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SA;
                    end
                end
                S_SD: begin
                    r_waddr <= AW'(r_idx + 1'b1);
                    r_wdata <= r_a;
                    r_valid[idx_a]             <= r_vb;
                    r_valid[AW'(r_idx + 1'b1)] <= r_va;
                    if (r_idx == DEPTH_C - 2'd2) begin
                        r_idx     <= '0;
                        r_swapped <= 1'b0;
                        r_state   <= S_SA;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SA;
                    end
                end
                S_OUT: begin
                    if (r_op == OP_SORT) r_status <= ST_OK;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_status      = (r_op == OP_SORT) ? ST_OK : r_status;
    assign o_found_slot  = r_fslot;
    assign o_entry_id    = r_eid;
    assign o_entry_valid = r_ev;
    assign o_stored_name = r_sname;
endmodule

@@ verif/record_slot_table_checker.sv @@
// ----------------------------------------------------------------------------
// record_slot_table_checker: slot table scoreboard
// Watches command and result ports, keeps its own copy of the slot table,
// predicts every result and compares it field by field in order.
// ----------------------------------------------------------------------------
module record_slot_table_checker
    import rst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_entry_name,
    input  logic [15:0] i_key_id,
    input  logic [3:0]  i_slot_index,
    input  logic        i_descending,
    input  logic        i_strobe,
    input  logic [1:0]  i_status,
    input  logic [3:0]  i_found_slot,
    input  logic [15:0] i_entry_id,
    input  logic        i_entry_valid,
    input  logic [63:0] i_stored_name,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);
    typedef struct packed {
        logic        valid;
        logic [15:0] id;
        logic [63:0] name;
    } slot_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  found_slot;
        logic [15:0] entry_id;
        logic        entry_valid;
        logic [63:0] stored_name;
    } table_result_t;

    localparam logic [63:0] NAME_MASK = ~64'd0 << (8 * (8 - NAME_BYTES_DEF));

    slot_t         slots [DEPTH_DEF];
    logic [15:0]   last_issued;
    table_result_t expected_results [$];

    function automatic int find_live_id(logic [15:0] key);
        for (int i = 0; i < DEPTH_DEF; i++)
            if (slots[i].valid && slots[i].id == key) return i;
        return -1;
    endfunction

    function automatic table_result_t slot_report(int s);
        table_result_t r;
        r.status      = ST_OK;
        r.found_slot  = s[3:0];
        r.entry_id    = slots[s].valid ? slots[s].id : 16'd0;
        r.entry_valid = slots[s].valid;
        r.stored_name = slots[s].name;
        return r;
    endfunction

    function automatic void bubble_sort(logic desc);
        slot_t tmp;
        logic  swapped;
        do begin
            swapped = 1'b0;
            for (int i = 0; i + 1 < DEPTH_DEF; i++) begin
                if (desc ? (slots[i].name < slots[i+1].name)
                         : (slots[i].name > slots[i+1].name)) begin
                    tmp = slots[i];
                    slots[i] = slots[i+1];
                    slots[i+1] = tmp;
                    swapped = 1'b1;
                end
            end
        end while (swapped);
    endfunction

    function automatic table_result_t apply_command(logic [2:0] op, logic [63:0] name_in,
                                                    logic [15:0] key, logic [3:0] idx,
                                                    logic desc);
        table_result_t r;
        logic [63:0]   name;
        int            s;
        name = name_in & NAME_MASK;
        r = '0;
        r.status = ST_FAIL;
        case (op)
            OP_INSERT: begin
                s = -1;
                for (int i = 0; i < DEPTH_DEF; i++)
                    if (!slots[i].valid && s < 0) s = i;
                if (s >= 0) begin
                    if (last_issued == TOP_ID) begin
                        r.status = ST_EXH;
                    end else begin
                        last_issued = last_issued + 16'd1;
                        slots[s].valid = 1'b1;
                        slots[s].id    = last_issued;
                        slots[s].name  = name;
                        r = slot_report(s);
                    end
                end
            end
            OP_RENAME: begin
                s = find_live_id(key);
                if (s >= 0) begin
                    slots[s].name = name;
                    r = slot_report(s);
                end
            end
            OP_REMOVE: begin
                s = find_live_id(key);
                if (s >= 0) begin
                    r = slot_report(s);
                    r.entry_valid = 1'b0;
                    slots[s].valid = 1'b0;
                end
            end
            OP_LOOKUP: begin
                s = find_live_id(key);
                if (s >= 0) r = slot_report(s);
            end
            OP_SORT: begin
                bubble_sort(desc);
                r.status = ST_OK;
            end
            OP_READ: begin
                if (int'(idx) < DEPTH_DEF) r = slot_report(int'(idx));
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        table_result_t got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH_DEF; i++) slots[i] = '0;
            last_issued = LAST_ID_RST;
            expected_results.delete();
            o_errors  <= 0;
            o_checked <= 0;
        end else begin
            if (i_strobe) begin
                got = {i_status, i_found_slot, i_entry_id, i_entry_valid, i_stored_name};
                if (expected_results.size() == 0) begin
                    if (o_errors < 10)
                        $display("[%0t] unexpected result %h", $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    o_checked <= o_checked + 1;
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("[%0t] mismatch: status %0d/%0d slot %0d/%0d id %0d/%0d valid %0b/%0b name %h/%h (exp/act)",
                                     $realtime, want.status, got.status,
                                     want.found_slot, got.found_slot,
                                     want.entry_id, got.entry_id,
                                     want.entry_valid, got.entry_valid,
                                     want.stored_name, got.stored_name);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            // command transfer
            if (i_start && !i_busy)
                expected_results.push_back(apply_command(i_operation, i_entry_name,
                                                         i_key_id, i_slot_index,
                                                         i_descending));
        end
        o_pending <= expected_results.size();
    end
endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: record slot table testbench
// Directed table-full, not-found, sort and bad-code cases, random command
// mixes under several sender idling phases, then the table is emptied.
// ----------------------------------------------------------------------------
module tb;
    import rst_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_operation;
    logic [63:0] i_entry_name;
    logic [15:0] i_key_id;
    logic [3:0]  i_slot_index;
    logic        i_descending;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [3:0]  o_found_slot;
    logic [15:0] o_entry_id;
    logic        o_entry_valid;
    logic [63:0] o_stored_name;
    int          fail_count;
    int          pending;
    int          checked;

    logic [15:0] recent_ids [8];
    int          recent_wr;
    logic [15:0] seen_id;
    logic        seen_valid;
    logic [63:0] name_pool [4];
    int          idle_pct;

    record_slot_table_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_entry_name(i_entry_name),
        .i_key_id(i_key_id), .i_slot_index(i_slot_index),
        .i_descending(i_descending), .o_strobe(o_strobe), .o_status(o_status),
        .o_found_slot(o_found_slot), .o_entry_id(o_entry_id),
        .o_entry_valid(o_entry_valid), .o_stored_name(o_stored_name)
    );

    record_slot_table_checker scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_operation(i_operation), .i_entry_name(i_entry_name),
        .i_key_id(i_key_id), .i_slot_index(i_slot_index),
        .i_descending(i_descending), .i_strobe(o_strobe), .i_status(o_status),
        .i_found_slot(o_found_slot), .i_entry_id(o_entry_id),
        .i_entry_valid(o_entry_valid), .i_stored_name(o_stored_name),
        .o_errors(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    // keep live-looking IDs around for keyed commands
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            recent_wr <= 0;
            for (int i = 0; i < 8; i++) recent_ids[i] <= LAST_ID_RST + 16'd1 + 16'(i);
        end else if (o_strobe) begin
            seen_id     <= o_entry_id;
            seen_valid  <= o_entry_valid;
            if (o_status == ST_OK && o_entry_id != 16'd0) begin
                recent_ids[recent_wr] <= o_entry_id;
                recent_wr <= (recent_wr + 1) % 8;
            end
        end
    end

    task automatic send(logic [2:0] op, logic [63:0] name, logic [15:0] key,
                        logic [3:0] idx, logic desc);
        i_operation  <= op;
        i_entry_name <= name;
        i_key_id     <= key;
        i_slot_index <= idx;
        i_descending <= desc;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_results;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_name;
        logic [63:0] n;
        int          k;
        if ($urandom_range(0, 99) < 30) return name_pool[$urandom_range(0, 3)];
        n = {$urandom, $urandom};
        k = $urandom_range(0, 7);
        if ($urandom_range(0, 1) == 1) n = n & (~64'd0 << (8 * k));
        return n;
    endfunction

    function automatic logic [15:0] pick_key;
        if ($urandom_range(0, 99) < 75) return recent_ids[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    task automatic random_command;
        int          w;
        logic [2:0]  op;
        w = $urandom_range(0, 99);
        if (w < 30)      op = OP_INSERT;
        else if (w < 45) op = OP_RENAME;
        else if (w < 65) op = OP_REMOVE;
        else if (w < 78) op = OP_LOOKUP;
        else if (w < 83) op = OP_SORT;
        else if (w < 97) op = OP_READ;
        else             op = ($urandom_range(0, 1) == 1) ? OP_SPARE_HI : OP_SPARE_LO;
        send(op, pick_name(), pick_key(), 4'($urandom), 1'($urandom));
    endtask

    initial begin
        name_pool[0] = "alpha";
        name_pool[1] = "bravo";
        name_pool[2] = 64'd0;
        name_pool[3] = ~64'd0;
        start <= 1'b0;
        i_operation <= OP_INSERT;
        i_entry_name <= '0;
        i_key_id <= '0;
        i_slot_index <= '0;
        i_descending <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every slot, equal names for sort stability, then overflow
        for (int i = 0; i < DEPTH_DEF; i++)
            send(OP_INSERT, (i % 3 == 0) ? name_pool[i % 4] : {$urandom, $urandom},
                 '0, '0, 1'b0);
        send(OP_INSERT, "overflow", '0, '0, 1'b0);
        send(OP_READ, '0, '0, 4'd0, 1'b0);
        send(OP_READ, '0, '0, 4'd15, 1'b0);
        send(OP_LOOKUP, '0, 16'd2005, '0, 1'b0);
        send(OP_LOOKUP, '0, 16'hFFFF, '0, 1'b0);
        send(OP_RENAME, ~64'd0, 16'd2003, '0, 1'b0);
        send(OP_REMOVE, '0, 16'd2007, '0, 1'b0);
        send(OP_REMOVE, '0, 16'd2007, '0, 1'b0);
        send(OP_SORT, '0, '0, '0, 1'b0);
        send(OP_READ, '0, '0, 4'd1, 1'b0);
        send(OP_SORT, '0, '0, '0, 1'b1);
        send(OP_SPARE_LO, '1, '1, '1, 1'b1);
        send(OP_SPARE_HI, '0, '0, '0, 1'b0);
        wait_results;

        // random phases: back to back, sparse sender, mostly busy sender, then a mixed one
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 68 : (phase == 2) ? 7 : (phase == 3) ? 30 : 0;
            for (int n = 0; n < 90; n++) begin
                random_command();
                if ($urandom_range(0, 99) < idle_pct) pause($urandom_range(1, 6));
            end
            wait_results;
        end

        // empty the table slot by slot
        for (int s = 0; s < DEPTH_DEF; s++) begin
            send(OP_READ, '0, '0, 4'(s), 1'b0);
            wait_results;
            if (seen_valid) begin
                send(OP_REMOVE, '0, seen_id, '0, 1'b0);
                wait_results;
            end
        end
        send(OP_INSERT, "late", '0, '0, 1'b0);
        send(OP_REMOVE, '0, TOP_ID, '0, 1'b0);
        send(OP_LOOKUP, '0, TOP_ID, '0, 1'b0);

        start <= 1'b0;
        for (int t = 0; t < 5000 && pending != 0; t++) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("covered: full table, unknown IDs, both sort orders, spare op codes, reads");
        $display("random mix under idling phases, table emptied; %0d results checked",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/rst_pkg.sv
rtl/record_slot_table_core.sv
verif/record_slot_table_checker.sv
verif/tb.sv
